// ===== sv/sorted_list_table_macros.svh =====
// Assertion macros shared by the sorted list table RTL.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold on every clock edge out of reset.
`define SLT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted list table: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list table: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list table: next-cycle check violated");

`else

`define SLT_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/slt_pkg.sv =====
// Types and codes shared by the sorted list table modules.
`timescale 1ns / 1ps
package slt_pkg;

  // Operation codes
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_RETRIEVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // Read address select
  localparam logic [1:0] RD_PREV = 2'd0;
  localparam logic [1:0] RD_CUR  = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;
  localparam logic [1:0] RD_POS  = 2'd3;

  // Index register update
  localparam logic [1:0] IDX_HOLD = 2'd0;
  localparam logic [1:0] IDX_INC  = 2'd1;
  localparam logic [1:0] IDX_DEC  = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [31:0] value;
    logic [5:0]        position;
  } slt_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [31:0] data;
    logic [5:0]        length;
    logic              empty_res;
  } slt_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_src_val;
    logic [1:0] idx_op;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       fin;
    logic [1:0] fin_status;
    logic       fin_data;
  } slt_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       idx_zero;
    logic       at_end;
    logic       last;
    logic       gt;
    logic       eq;
    logic       pos_ok;
  } slt_sts_t;

endpackage

// ===== sv/slt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/slt_datapath.sv =====
// Datapath: entry RAM, index and count registers, compare and result registers.
`timescale 1ns / 1ps
`include "sorted_list_table_macros.svh"
module slt_datapath import slt_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  slt_in_t  in_item,
  input  slt_ctl_t ctl,
  output slt_sts_t sts,
  output logic     out_valid,
  output slt_out_t out_item
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [1:0]            cmd_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [5:0]            pos_r;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r;
  slt_out_t              out_item_r;

  logic [CNT_W-1:0]      idx_m1, idx_p1;
  logic [CMP_W-1:0]      pos_ext, cnt_ext, pos_m1;
  logic [IDX_W-1:0]      raddr;
  logic [VALUE_BITS-1:0] wdata, rd_data;

  assign idx_m1  = idx_r - 1'b1;
  assign idx_p1  = idx_r + 1'b1;
  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_m1  = pos_ext - 1'b1;

  always_comb begin
    case (ctl.rd_sel)
      RD_PREV: raddr = idx_m1[IDX_W-1:0];
      RD_CUR:  raddr = idx_r[IDX_W-1:0];
      RD_NEXT: raddr = idx_p1[IDX_W-1:0];
      RD_POS:  raddr = pos_m1[IDX_W-1:0];
      default: raddr = idx_r[IDX_W-1:0];
    endcase
  end

  assign wdata = ctl.wr_src_val ? val_r : rd_data;

  slt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (idx_r[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    case (ctl.idx_op)
      IDX_INC: idx_nxt = idx_p1;
      IDX_DEC: idx_nxt = idx_m1;
      default: idx_nxt = idx_r;
    endcase
    if (ctl.load) begin
      idx_nxt = (in_item.cmd == CMD_INSERT) ? count_r : '0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= ctl.fin;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.load) begin
      cmd_r <= in_item.cmd;
      val_r <= VALUE_BITS'(in_item.value);
      pos_r <= in_item.position;
    end
    if (ctl.fin) begin
      out_item_r.status    <= ctl.fin_status;
      out_item_r.data      <= ctl.fin_data ? 32'($signed(rd_data)) : '0;
      out_item_r.length    <= 6'(count_nxt);
      out_item_r.empty_res <= (count_nxt == '0);
    end
  end

  assign sts.cmd      = cmd_r;
  assign sts.full     = (count_r >= CAP_CNT);
  assign sts.idx_zero = (idx_r == '0);
  assign sts.at_end   = (idx_r >= count_r);
  assign sts.last     = (idx_p1 >= count_r);
  assign sts.gt       = ($signed(rd_data) > $signed(val_r));
  assign sts.eq       = (rd_data == val_r);
  assign sts.pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SLT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CAP_CNT)
  `SLT_ASSERT_IMP(a_wr_in_range, clk, rst_n, ctl.wr_en, idx_r < CAP_CNT)
  `SLT_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid_r, !out_valid_r)

endmodule

// ===== sv/slt_controller.sv =====
// Controller: sequences insert, remove and retrieve over the entry RAM.
`timescale 1ns / 1ps
`include "sorted_list_table_macros.svh"
module slt_controller import slt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  slt_sts_t sts,
  output logic     busy,
  output slt_ctl_t ctl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_CMP  = 4'd3;
  localparam logic [3:0] S_RM_RD    = 4'd4;
  localparam logic [3:0] S_RM_CMP   = 4'd5;
  localparam logic [3:0] S_SH_RD    = 4'd6;
  localparam logic [3:0] S_SH_WR    = 4'd7;
  localparam logic [3:0] S_RT_RD    = 4'd8;
  localparam logic [3:0] S_RT_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    ctl            = '0;
    ctl.rd_sel     = RD_CUR;
    ctl.idx_op     = IDX_HOLD;
    ctl.fin_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.full) begin
              ctl.fin        = 1'b1;
              ctl.fin_status = ST_FULL;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_INS_RD;
            end
          end
          CMD_REMOVE:   state_nxt = S_RM_RD;
          CMD_RETRIEVE: state_nxt = S_RT_RD;
          default: begin
            ctl.fin   = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_INS_RD: begin
        if (sts.idx_zero) begin
          // place at the bottom slot
          ctl.wr_en      = 1'b1;
          ctl.wr_src_val = 1'b1;
          ctl.cnt_inc    = 1'b1;
          ctl.fin        = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          ctl.rd_sel = RD_PREV;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.gt) begin
          // shift the larger entry up one slot
          ctl.wr_en  = 1'b1;
          ctl.idx_op = IDX_DEC;
          state_nxt  = S_INS_RD;
        end else begin
          ctl.wr_en      = 1'b1;
          ctl.wr_src_val = 1'b1;
          ctl.cnt_inc    = 1'b1;
          ctl.fin        = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RM_RD: begin
        if (sts.at_end) begin
          ctl.fin        = 1'b1;
          ctl.fin_status = ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          ctl.rd_sel = RD_CUR;
          state_nxt  = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (sts.eq) begin
          state_nxt = S_SH_RD;
        end else begin
          ctl.idx_op = IDX_INC;
          state_nxt  = S_RM_RD;
        end
      end
      S_SH_RD: begin
        if (sts.last) begin
          ctl.cnt_dec = 1'b1;
          ctl.fin     = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          ctl.rd_sel = RD_NEXT;
          state_nxt  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        // close the gap one slot down
        ctl.wr_en  = 1'b1;
        ctl.idx_op = IDX_INC;
        state_nxt  = S_SH_RD;
      end
      S_RT_RD: begin
        if (sts.pos_ok) begin
          ctl.rd_sel = RD_POS;
          state_nxt  = S_RT_OUT;
        end else begin
          ctl.fin        = 1'b1;
          ctl.fin_status = ST_RANGE;
          state_nxt      = S_IDLE;
        end
      end
      S_RT_OUT: begin
        ctl.fin      = 1'b1;
        ctl.fin_data = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `SLT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `SLT_ASSERT_NXT(a_fin_idle, clk, rst_n, ctl.fin, !busy)
  `SLT_ASSERT_IMP(a_wr_when_busy, clk, rst_n, ctl.wr_en, busy && !ctl.load)

endmodule

// ===== sv/sorted_list_table.sv =====
// Sorted list table: one item at a time; busy is high from acceptance until the result.
// Full inserts and unused codes skip the RAM; a retrieve reads at most one entry.
// Other items visit entries, each with one registered RAM read, then a compare or write.
// The single RAM read port with registered data sets this read-then-act step per entry.
// The result strobe out_valid lasts one cycle; the next item can be taken in that cycle.
// Synchronous active-low reset empties the table; entry contents are not cleared.
`timescale 1ns / 1ps
module sorted_list_table import slt_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  slt_in_t  in_item,
  output logic     out_valid,
  output slt_out_t out_item
);

  slt_ctl_t ctl;
  slt_sts_t sts;

  slt_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  slt_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== verif/slt_checker.sv =====
// Watches the sorted list table channels, predicts every result and compares it.
`timescale 1ns / 1ps
module slt_checker import slt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  slt_in_t  in_item,
  input  logic     out_valid,
  input  slt_out_t out_item,
  output int       fail_count,
  output int       pending
);

  localparam int DEPTH     = 32;
  localparam int MAX_LINES = 40;

  logic signed [31:0] sorted_vals [DEPTH];
  int                 fill = 0;
  int                 mismatches = 0;
  slt_out_t           pending_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_LINES)
      $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Apply one item to the shadow list and return the result it should give.
  function automatic slt_out_t apply_table_op(input slt_in_t op);
    slt_out_t           res;
    int                 i;
    logic signed [31:0] val;
    res = '0;
    res.status = ST_OK;
    val = $signed(op.value);
    case (op.cmd)
      CMD_INSERT: begin
        if (fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // shift larger entries up; equal ones stay below the new value
          i = fill;
          while (i > 0 && $signed(sorted_vals[i-1]) > val) begin
            sorted_vals[i] = sorted_vals[i-1];
            i--;
          end
          sorted_vals[i] = val;
          fill++;
        end
      end
      CMD_REMOVE: begin
        i = 0;
        while (i < fill && sorted_vals[i] != val) i++;
        if (i >= fill) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (; i + 1 < fill; i++) sorted_vals[i] = sorted_vals[i+1];
          fill--;
        end
      end
      CMD_RETRIEVE: begin
        if (op.position >= 1 && int'(op.position) <= fill)
          res.data = sorted_vals[op.position - 1];
        else
          res.status = ST_RANGE;
      end
      default: ;
    endcase
    res.length    = fill[5:0];
    res.empty_res = (fill == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    slt_out_t want;
    if (!rst_n) begin
      fill = 0;
      pending_results.delete();
    end else begin
      // compare first: a result always belongs to an item taken earlier
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item waiting", 32'(out_item.status), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.data !== want.data)
            report_mismatch("data", out_item.data, want.data);
          if (out_item.length !== want.length)
            report_mismatch("length", 32'(out_item.length), 32'(want.length));
          if (out_item.empty_res !== want.empty_res)
            report_mismatch("empty_res", 32'(out_item.empty_res), 32'(want.empty_res));
        end
      end
      if (start && !busy) pending_results.push_back(apply_table_op(in_item));
    end
    fail_count <= mismatches;
    pending    <= pending_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the sorted list table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import slt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 950;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  slt_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  slt_out_t out_item;
  int       fail_count;
  int       pending;
  int       cycles = 0;
  int       burst_left = 0;

  sorted_list_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  slt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL sorted_list_table");
      $finish;
    end
  end

  function automatic slt_in_t mk(input logic [1:0] cmd, input logic [31:0] value,
                                 input logic [5:0] position);
    slt_in_t op;
    op.cmd      = cmd;
    op.value    = value;
    op.position = position;
    return op;
  endfunction

  // Mostly a small pool so removes hit and duplicates pile up; otherwise any value.
  function automatic logic [31:0] pick_value();
    logic [31:0] pool [12];
    pool = '{VAL_MIN, VAL_MAX, 32'd0, 32'hffff_ffff, 32'd1, 32'd7, -32'sd7, 32'd100,
             -32'sd100, 32'h5555_5555, 32'haaaa_aaaa, 32'd42};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 6'($urandom_range(0, 33));
    if (r < 7) return 6'($urandom_range(1, 8));
    return 6'($urandom_range(0, 63));
  endfunction

  // Filling phases lean on insert, draining phases on remove.
  function automatic slt_in_t rand_op(input bit filling);
    int          r;
    logic [1:0]  cmd;
    r = $urandom_range(0, 99);
    if (r < 5)                        cmd = CMD_UNUSED;
    else if (r < (filling ? 70 : 20)) cmd = CMD_INSERT;
    else if (r < 80)                  cmd = CMD_REMOVE;
    else                              cmd = CMD_RETRIEVE;
    return mk(cmd, pick_value(), pick_position());
  endfunction

  // Hold the item until taken, then either go on in the burst or idle a while.
  task automatic send_op(input slt_in_t op);
    start   <= 1'b1;
    in_item <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  initial begin
    int n;
    int phase_left;
    bit filling;
    n = 0;
    filling = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table corner cases
    send_op(mk(CMD_RETRIEVE, 32'd0, 6'd1));
    send_op(mk(CMD_REMOVE, 32'd0, 6'd0));
    send_op(mk(CMD_UNUSED, 32'hdead_beef, 6'd63));
    // extremes and duplicates
    send_op(mk(CMD_INSERT, VAL_MAX, 6'd0));
    send_op(mk(CMD_INSERT, VAL_MIN, 6'd0));
    send_op(mk(CMD_INSERT, 32'd0, 6'd0));
    send_op(mk(CMD_INSERT, 32'd0, 6'd63));
    send_op(mk(CMD_INSERT, 32'hffff_ffff, 6'd0));
    // positions: zero, first, last, one past the end, top of the field
    send_op(mk(CMD_RETRIEVE, 32'd0, 6'd0));
    send_op(mk(CMD_RETRIEVE, 32'd0, 6'd1));
    send_op(mk(CMD_RETRIEVE, 32'hffff_ffff, 6'd5));
    send_op(mk(CMD_RETRIEVE, 32'd0, 6'd6));
    send_op(mk(CMD_RETRIEVE, 32'd0, 6'd63));
    // drop a duplicate, miss an absent value, drop both ends
    send_op(mk(CMD_REMOVE, 32'd0, 6'd0));
    send_op(mk(CMD_REMOVE, 32'd12345, 6'd0));
    send_op(mk(CMD_REMOVE, VAL_MAX, 6'd0));
    send_op(mk(CMD_REMOVE, VAL_MIN, 6'd0));
    send_op(mk(CMD_UNUSED, 32'h1234_5678, 6'd2));
    send_op(mk(CMD_RETRIEVE, 32'd0, 6'd2));
    send_op(mk(CMD_REMOVE, 32'd0, 6'd0));
    send_op(mk(CMD_REMOVE, 32'hffff_ffff, 6'd0));
    send_op(mk(CMD_RETRIEVE, 32'd0, 6'd1));

    while (n < ITEM_TARGET) begin
      phase_left = $urandom_range(60, 160);
      while (phase_left > 0 && n < ITEM_TARGET) begin
        send_op(rand_op(filling));
        n++;
        phase_left--;
      end
      filling = !filling;
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sorted_list_table");
    end else begin
      $display("FAIL sorted_list_table");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/slt_pkg.sv
sv/slt_ram.sv
sv/slt_datapath.sv
sv/slt_controller.sv
sv/sorted_list_table.sv
verif/slt_checker.sv
verif/tb_top.sv
